// ----- rtl/flc_pkg.sv -----
package flc_pkg;

	// Sizes of the filter.
	localparam int MAX_TAPS    = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int RING_LEN    = (MAX_TAPS > 1) ? (MAX_TAPS - 1) : 1;
	localparam int K_W         = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int H_W         = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
	localparam int TAPS_W      = 7;
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;
	localparam int PROD_W      = 2 * SAMPLE_BITS;
	localparam int ACC_W       = PROD_W + K_W;
	localparam int Q_W         = ACC_W - FRAC_BITS;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] ADDR_TAP_COUNT = CFG_ADDR_W'(0);
	localparam logic [TAPS_W-1:0] TAP_COUNT_RESET = TAPS_W'(64);

	// Item kinds.
	localparam logic MODE_COEF   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic                          mode;
		logic [5:0]                    tap_index;
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          block_end;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic                          clipped;
		logic                          final_res;
	} result_t;

endpackage

// ----- rtl/fir_linear_convolution.sv -----
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    flc_pkg::item_t
// result    out        result_valid / result_stall flc_pkg::result_t
// config    in         APB write/read, paddr 0    tap_count
//
// A coefficient beat is taken at once while the block is idle. A sample beat
// makes one output: one shared multiply-accumulate unit runs once per tap,
// then the read, multiply and add stages drain before the output is loaded.
// A block-end sample adds taps-in-use - 1 tail outputs, and the next beat
// is taken in the cycle after the last output is loaded.
// Reset clears the coefficient and history valid bits at once; no sweep.
// The block takes no item while an output is in progress; a finished output
// waits in its register while a new item is taken.
module fir_linear_convolution (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  flc_pkg::item_t                     item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output flc_pkg::result_t                   result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [flc_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [flc_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [flc_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import flc_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

	state_t                   state_q;
	logic [TAPS_W-1:0]        tap_count_q;
	logic [K_W-1:0]           k_q;
	logic [K_W-1:0]           last_k_q;
	logic [K_W-1:0]           rem_q;
	logic                     end_q;
	logic [H_W-1:0]           ptr_q;
	logic [H_W-1:0]           hidx_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [MAX_TAPS-1:0]      cv_q;
	logic [RING_LEN-1:0]      hv_q;
	logic                     result_valid_q;
	result_t                  result_q;

	logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] hist_mem [RING_LEN];

	// Pipeline of the shared MAC.
	logic                          vld_s1, vld_s2;
	logic                          first_s1, first_s2;
	logic                          cv_s1, hv_s1;
	logic signed [SAMPLE_BITS-1:0] coef_rd_s1, hist_rd_s1, x_s1;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [ACC_W-1:0]       acc_q;

	logic                     item_acc, coef_we, sample_go, issue, load, final_out;
	logic [TAPS_W-1:0]        taps_act;
	logic [H_W-1:0]           ptr_next;
	logic signed [ACC_W-1:0]  acc_rnd;
	logic signed [Q_W-1:0]    q_full;
	logic                     clip_hi, clip_lo;
	logic signed [SAMPLE_BITS-1:0] q_sat;
	logic signed [SAMPLE_BITS-1:0] op_a, op_b;

	// Handshake and control decodes.
	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign coef_we      = item_acc && (item.mode == MODE_COEF);
	assign sample_go    = item_acc && (item.mode == MODE_SAMPLE);
	assign issue        = (state_q == S_RUN);
	assign load         = (state_q == S_DRAIN) && !vld_s1 && !vld_s2 &&
	                      (!result_valid_q || !result_stall);
	assign final_out    = end_q && (rem_q == '0);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Tap count in use: zero acts as one, anything above the maximum is clamped.
	always_comb begin
		if (tap_count_q == '0) begin
			taps_act = TAPS_W'(1);
		end else if (tap_count_q > TAPS_W'(MAX_TAPS)) begin
			taps_act = TAPS_W'(MAX_TAPS);
		end else begin
			taps_act = tap_count_q;
		end
	end

	assign ptr_next = (ptr_q == H_W'(RING_LEN - 1)) ? '0 : ptr_q + H_W'(1);

	// Configuration registers.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_TAP_COUNT) ? CFG_DATA_W'(tap_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_TAP_COUNT) begin
			tap_count_q <= pwdata[TAPS_W-1:0];
		end
	end

	// Round half up, then saturate to the output range.
	assign acc_rnd = acc_q + ACC_W'(1 << (FRAC_BITS - 1));
	assign q_full  = acc_rnd[ACC_W-1:FRAC_BITS];
	assign clip_hi = !q_full[Q_W-1] && (|q_full[Q_W-2:SAMPLE_BITS-1]);
	assign clip_lo = q_full[Q_W-1] && !(&q_full[Q_W-2:SAMPLE_BITS-1]);

	always_comb begin
		if (clip_hi) begin
			q_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (clip_lo) begin
			q_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			q_sat = q_full[SAMPLE_BITS-1:0];
		end
	end

	// Sequencer: state, counters, valid bits and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			k_q            <= '0;
			last_k_q       <= '0;
			rem_q          <= '0;
			end_q          <= 1'b0;
			ptr_q          <= '0;
			hidx_q         <= '0;
			x_q            <= '0;
			cv_q           <= '0;
			hv_q           <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// The result register fills on a load and empties when its beat is taken.
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (coef_we) begin
				cv_q[item.tap_index[K_W-1:0]] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (sample_go) begin
						x_q      <= item.value;
						last_k_q <= K_W'(taps_act - TAPS_W'(1));
						rem_q    <= item.block_end ? K_W'(taps_act - TAPS_W'(1)) : '0;
						end_q    <= item.block_end;
						k_q      <= '0;
						hidx_q   <= ptr_q;
						state_q  <= S_RUN;
					end
				end
				S_RUN: begin
					if (k_q == last_k_q) begin
						state_q <= S_DRAIN;
					end else begin
						k_q    <= k_q + K_W'(1);
						hidx_q <= (hidx_q == '0) ? H_W'(RING_LEN - 1) : hidx_q - H_W'(1);
					end
				end
				S_DRAIN: begin
					if (load) begin
						result_q.out_sample <= q_sat;
						result_q.clipped    <= clip_hi || clip_lo;
						result_q.final_res  <= final_out;
						if (final_out) begin
							// Block done: the history starts from zero again.
							hv_q    <= '0;
							ptr_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							hv_q[ptr_q] <= 1'b1;
							ptr_q       <= ptr_next;
							if (rem_q == '0) begin
								state_q <= S_IDLE;
							end else begin
								// Next tail output, fed with a zero sample.
								rem_q   <= rem_q - K_W'(1);
								x_q     <= '0;
								k_q     <= '0;
								hidx_q  <= ptr_next;
								state_q <= S_RUN;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Coefficient store and sample history, one read port each.
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[item.tap_index[K_W-1:0]] <= item.value;
		end
		if (load && !final_out) begin
			hist_mem[ptr_q] <= x_q;
		end
		coef_rd_s1 <= coef_mem[k_q];
		hist_rd_s1 <= hist_mem[hidx_q];
	end

	// MAC pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	// Operand select: an entry never written reads as zero.
	assign op_a = cv_s1 ? coef_rd_s1 : '0;
	assign op_b = first_s1 ? x_s1 : (hv_s1 ? hist_rd_s1 : '0);

	// Read, multiply and accumulate stages.
	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		cv_s1    <= cv_q[k_q];
		hv_s1    <= hv_q[hidx_q];
		x_s1     <= x_q;
		first_s2 <= first_s1;
		prod_s2  <= op_a * op_b;
		if (vld_s2) begin
			acc_q <= (first_s2 ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);
		end
	end

	// The MAC pipeline is busy only while an output is in progress.
	a_pipe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q != S_IDLE))
		else $error("MAC stage active while idle");

	// A new output never overwrites one still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!result_valid_q || !result_stall))
		else $error("result register overwritten");

	// The tap counter stays within the taps in use.
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (k_q <= last_k_q))
		else $error("tap counter out of range");

	// The final output of a block leaves the history cleared.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(load && final_out) |=> (ptr_q == '0 && hv_q == '0 && state_q == S_IDLE))
		else $error("history not cleared at block end");

endmodule
